// ===== rtl/shelf_atlas_packer_defines.svh =====
// assertion helpers, clocked on clk and disabled while rst is high
`ifndef SHELF_ATLAS_PACKER_DEFINES_SVH
`define SHELF_ATLAS_PACKER_DEFINES_SVH

// same-cycle implication
`define SAP_ASSERT_IMPL(name, a, c) \
  name: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("shelf atlas packer assertion failed");

// next-cycle implication
`define SAP_ASSERT_NEXT(name, a, c) \
  name: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("shelf atlas packer assertion failed");

`endif

// ===== rtl/sap_pkg.sv =====
package sap_pkg;

  localparam int unsigned DIM_W = 16;
  localparam int unsigned CUR_W = 18;
  localparam int unsigned Q_W   = 17;
  localparam int unsigned SUM_W = 20;

  localparam logic [Q_W-1:0]   Q16_ONE    = 17'h10000;
  localparam logic [CUR_W-1:0] CURSOR_MAX = 18'h3ffff;

  localparam logic [DIM_W-1:0] ATLAS_W_RESET  = 16'd1024;
  localparam logic [DIM_W-1:0] ATLAS_H_RESET  = 16'd1024;
  localparam logic [DIM_W-1:0] BASE_PAD_RESET = 16'd0;

  // register indexes on the configuration port
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_PADDING = 2'd2;

  // shared divider: 16 fraction bits, four per cycle
  localparam int unsigned DIV_BITS_PER_STEP = 4;
  localparam int unsigned DIV_STEPS = DIM_W / DIV_BITS_PER_STEP;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  // division slots of one item
  localparam int unsigned NUM_DIVS  = 6;
  localparam int unsigned DIV_IDX_W = $clog2(NUM_DIVS);
  localparam logic [DIV_IDX_W-1:0] DIV_UV_U  = 3'd0;
  localparam logic [DIV_IDX_W-1:0] DIV_UV_V  = 3'd1;
  localparam logic [DIV_IDX_W-1:0] DIV_UV_W  = 3'd2;
  localparam logic [DIV_IDX_W-1:0] DIV_UV_H  = 3'd3;
  localparam logic [DIV_IDX_W-1:0] DIV_INV_W = 3'd4;
  localparam logic [DIV_IDX_W-1:0] DIV_INV_H = 3'd5;

  typedef struct packed {
    logic             start_pass;
    logic             tex_present;
    logic [DIM_W-1:0] tex_width;
    logic [DIM_W-1:0] tex_height;
    logic [DIM_W-1:0] fallback_width;
    logic [DIM_W-1:0] fallback_height;
    logic [DIM_W-1:0] entry_padding;
  } item_t;

  typedef struct packed {
    logic             placed;
    logic [DIM_W-1:0] pos_x;
    logic [DIM_W-1:0] pos_y;
    logic [DIM_W-1:0] size_w;
    logic [DIM_W-1:0] size_h;
    logic [Q_W-1:0]   uv_u;
    logic [Q_W-1:0]   uv_v;
    logic [Q_W-1:0]   uv_w;
    logic [Q_W-1:0]   uv_h;
    logic [Q_W-1:0]   inv_w;
    logic [Q_W-1:0]   inv_h;
  } result_t;

  typedef struct packed {
    logic load;
    logic start;
    logic clamp;
    logic fit;
    logic row;
    logic check;
    logic commit;
  } shelf_cmd_t;

  typedef struct packed {
    logic             placed;
    logic [CUR_W-1:0] cx;
    logic [CUR_W-1:0] cy;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
  } geom_t;

  typedef struct packed {
    logic             start;
    logic [CUR_W-1:0] num;
    logic [DIM_W-1:0] den;
  } div_cmd_t;

  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] quot;
  } div_stat_t;

endpackage

// ===== rtl/sap_div.sv =====
module sap_div (
  input  logic                 clk,
  input  logic                 rst,
  input  sap_pkg::div_cmd_t    cmd,
  output sap_pkg::div_stat_t   stat
);

  logic                            busy;
  logic                            done;
  logic [sap_pkg::DIV_CNT_W-1:0]   cnt;
  logic                            sat;
  logic [sap_pkg::DIM_W-1:0]       den;
  logic [sap_pkg::DIM_W-1:0]       rem;
  logic [sap_pkg::DIM_W-1:0]       quot;
  logic [sap_pkg::DIM_W-1:0]       rem_next;
  logic [sap_pkg::DIM_W-1:0]       quot_next;
  logic                            sat_next;

  // num >= den gives a ratio of at least one, which saturates
  assign sat_next = cmd.num >= {2'b00, cmd.den};

  // restoring steps, DIV_BITS_PER_STEP quotient bits at a time
  always_comb begin
    logic [sap_pkg::DIM_W:0] t;
    rem_next  = rem;
    quot_next = quot;
    for (int i = 0; i < sap_pkg::DIV_BITS_PER_STEP; i++) begin
      t = {rem_next, 1'b0};
      if (t >= {1'b0, den}) begin
        rem_next  = sap_pkg::DIM_W'(t - {1'b0, den});
        quot_next = {quot_next[sap_pkg::DIM_W-2:0], 1'b1};
      end else begin
        rem_next  = t[sap_pkg::DIM_W-1:0];
        quot_next = {quot_next[sap_pkg::DIM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (cmd.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == sap_pkg::DIV_CNT_W'(sap_pkg::DIV_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      den  <= cmd.den;
      sat  <= sat_next;
      rem  <= sat_next ? '0 : cmd.num[sap_pkg::DIM_W-1:0];
      quot <= '0;
    end else if (busy) begin
      rem  <= rem_next;
      quot <= quot_next;
    end
  end

  assign stat.done = done;
  assign stat.quot = sat ? sap_pkg::Q16_ONE : {1'b0, quot};

endmodule

// ===== rtl/sap_shelf.sv =====
module sap_shelf (
  input  logic                       clk,
  input  logic                       rst,
  input  sap_pkg::shelf_cmd_t        cmd,
  input  sap_pkg::item_t             item,
  input  logic [sap_pkg::DIM_W-1:0]  aw,
  input  logic [sap_pkg::DIM_W-1:0]  ah,
  input  logic [sap_pkg::DIM_W-1:0]  bp,
  output sap_pkg::geom_t             geom
);

  logic [sap_pkg::CUR_W-1:0] cx;
  logic [sap_pkg::CUR_W-1:0] cy;
  logic [sap_pkg::DIM_W-1:0] rh;
  logic                      placed;
  logic [sap_pkg::DIM_W-1:0] pad;
  logic [sap_pkg::DIM_W-1:0] w;
  logic [sap_pkg::DIM_W-1:0] h;
  logic [sap_pkg::DIM_W-1:0] room_w;
  logic [sap_pkg::DIM_W-1:0] room_h;

  logic [sap_pkg::DIM_W-1:0] size_w_sel;
  logic [sap_pkg::DIM_W-1:0] size_h_sel;
  logic [sap_pkg::DIM_W-1:0] pad_sel;
  logic [sap_pkg::DIM_W:0]   pad2;
  logic [sap_pkg::DIM_W-1:0] room_w_calc;
  logic [sap_pkg::DIM_W-1:0] room_h_calc;
  logic [sap_pkg::DIM_W-1:0] lim_w;
  logic [sap_pkg::DIM_W-1:0] lim_h;
  logic [sap_pkg::DIM_W-1:0] w_fit;
  logic [sap_pkg::DIM_W-1:0] h_fit;
  logic [sap_pkg::SUM_W-1:0] sum_x;
  logic [sap_pkg::SUM_W-1:0] sum_y;
  logic [sap_pkg::SUM_W-1:0] bottom;
  logic [sap_pkg::CUR_W-1:0] next_row_y;
  logic                      row_new;
  logic                      fits;

  always_comb begin
    size_w_sel = item.tex_present ? item.tex_width  : item.fallback_width;
    size_h_sel = item.tex_present ? item.tex_height : item.fallback_height;
    if (size_w_sel == '0) size_w_sel = sap_pkg::DIM_W'(1);
    if (size_h_sel == '0) size_h_sel = sap_pkg::DIM_W'(1);
    pad_sel = (item.entry_padding > bp) ? item.entry_padding : bp;
  end

  // room left after padding on both sides, zero when padding eats the atlas
  assign pad2        = {pad, 1'b0};
  assign room_w_calc = ({1'b0, aw} > pad2) ? aw - pad2[sap_pkg::DIM_W-1:0] : '0;
  assign room_h_calc = ({1'b0, ah} > pad2) ? ah - pad2[sap_pkg::DIM_W-1:0] : '0;
  assign lim_w       = (room_w == '0) ? sap_pkg::DIM_W'(1) : room_w;
  assign lim_h       = (room_h == '0) ? sap_pkg::DIM_W'(1) : room_h;
  assign w_fit       = (w < lim_w) ? w : lim_w;
  assign h_fit       = (h < lim_h) ? h : lim_h;

  assign sum_x   = {2'b00, cx} + {4'b0000, w} + {4'b0000, pad};
  assign row_new = sum_x > {4'b0000, aw};
  assign sum_y   = {2'b00, cy} + {4'b0000, rh} + {4'b0000, bp};
  assign next_row_y = (sum_y > {2'b00, sap_pkg::CURSOR_MAX}) ? sap_pkg::CURSOR_MAX
                                                             : sum_y[sap_pkg::CUR_W-1:0];
  assign bottom  = {2'b00, cy} + {4'b0000, h} + {4'b0000, pad};
  assign fits    = bottom <= {4'b0000, ah};

  // cursor state
  always_ff @(posedge clk) begin
    if (rst) begin
      cx     <= {2'b00, sap_pkg::BASE_PAD_RESET};
      cy     <= {2'b00, sap_pkg::BASE_PAD_RESET};
      rh     <= '0;
      placed <= 1'b0;
    end else begin
      if (cmd.load && cmd.start) begin
        cx <= {2'b00, bp};
        cy <= {2'b00, bp};
        rh <= '0;
      end
      if (cmd.row && row_new) begin
        cx <= {2'b00, bp};
        cy <= next_row_y;
        rh <= '0;
      end
      if (cmd.check) placed <= fits;
      if (cmd.commit && placed) begin
        cx <= sum_x[sap_pkg::CUR_W-1:0];
        rh <= (h > rh) ? h : rh;
      end
    end
  end

  // per-item working values
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      w   <= size_w_sel;
      h   <= size_h_sel;
      pad <= pad_sel;
    end
    if (cmd.clamp) begin
      room_w <= room_w_calc;
      room_h <= room_h_calc;
    end
    if (cmd.fit) begin
      w <= w_fit;
      h <= h_fit;
    end
  end

  assign geom.placed = placed;
  assign geom.cx     = cx;
  assign geom.cy     = cy;
  assign geom.w      = w;
  assign geom.h      = h;

endmodule

// ===== rtl/shelf_atlas_packer.sv =====
// shelf atlas packer: places rectangles row by row in a fixed atlas
//
// item channel: item_valid / item_stall / item; a request is taken when
// item_valid is high and item_stall is low. item_stall stays high while an
// item is being worked on and during reset.
// result channel: result_valid / result_stall / result; exactly one result
// per item, held in an output register until taken, so the next item is
// accepted while a result still waits.
// config channel: cfg_valid / cfg_ready / cfg_index / cfg_data, ready outside
// reset; index 0 atlas width, 1 atlas height, 2 base padding. write only when idle.
// items are taken one at a time: a new item is accepted only after the previous
// one has left ST_DONE. the work is four geometry steps followed by
// six divisions on one shared divider (four quotient bits per
// cycle). if the previous result is still stalled the new result waits.
// reset: atlas 1024 x 1024, base padding 0, cursors and row height 0, no
// result pending.
`include "shelf_atlas_packer_defines.svh"

module shelf_atlas_packer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  sap_pkg::item_t                 item,
  output logic                           result_valid,
  input  logic                           result_stall,
  output sap_pkg::result_t               result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sap_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sap_pkg::DIM_W-1:0]      cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_FIT,
    ST_ROW,
    ST_CHECK,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t                          state;
  logic [sap_pkg::DIV_IDX_W-1:0]   k;
  logic                            issue;
  logic [sap_pkg::Q_W-1:0]         quot [sap_pkg::NUM_DIVS];

  logic [sap_pkg::DIM_W-1:0]       atlas_width;
  logic [sap_pkg::DIM_W-1:0]       atlas_height;
  logic [sap_pkg::DIM_W-1:0]       base_padding;
  logic [sap_pkg::DIM_W-1:0]       aw;
  logic [sap_pkg::DIM_W-1:0]       ah;

  logic                            accept;
  logic                            out_free;
  logic [sap_pkg::DIV_IDX_W-1:0]   op_k;
  sap_pkg::shelf_cmd_t             shelf_cmd;
  sap_pkg::geom_t                  geom;
  sap_pkg::div_cmd_t               div_cmd;
  sap_pkg::div_stat_t              div_stat;
  sap_pkg::result_t                result_next;

  assign cfg_ready  = !rst;
  assign item_stall = rst || (state != ST_IDLE);
  assign accept     = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;

  assign aw = (atlas_width  == '0) ? sap_pkg::DIM_W'(1) : atlas_width;
  assign ah = (atlas_height == '0) ? sap_pkg::DIM_W'(1) : atlas_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      atlas_width  <= sap_pkg::ATLAS_W_RESET;
      atlas_height <= sap_pkg::ATLAS_H_RESET;
      base_padding <= sap_pkg::BASE_PAD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sap_pkg::CFG_ATLAS_WIDTH:  atlas_width  <= cfg_data;
        sap_pkg::CFG_ATLAS_HEIGHT: atlas_height <= cfg_data;
        sap_pkg::CFG_BASE_PADDING: base_padding <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    shelf_cmd.load   = accept;
    shelf_cmd.start  = accept && item.start_pass;
    shelf_cmd.clamp  = (state == ST_CLAMP);
    shelf_cmd.fit    = (state == ST_FIT);
    shelf_cmd.row    = (state == ST_ROW);
    shelf_cmd.check  = (state == ST_CHECK);
    shelf_cmd.commit = (state == ST_DONE) && out_free;
  end

  sap_shelf u_shelf (
    .clk  (clk),
    .rst  (rst),
    .cmd  (shelf_cmd),
    .item (item),
    .aw   (aw),
    .ah   (ah),
    .bp   (base_padding),
    .geom (geom)
  );

  // the next division starts in the cycle the previous one finishes
  assign op_k = div_stat.done ? k + 1'b1 : k;

  always_comb begin
    div_cmd.start = (state == ST_DIV) &&
                    (issue || (div_stat.done && k != sap_pkg::DIV_INV_H));
    case (op_k)
      sap_pkg::DIV_UV_U: begin
        div_cmd.num = geom.cx;
        div_cmd.den = aw;
      end
      sap_pkg::DIV_UV_V: begin
        div_cmd.num = geom.cy;
        div_cmd.den = ah;
      end
      sap_pkg::DIV_UV_W: begin
        div_cmd.num = {2'b00, geom.w};
        div_cmd.den = aw;
      end
      sap_pkg::DIV_UV_H: begin
        div_cmd.num = {2'b00, geom.h};
        div_cmd.den = ah;
      end
      sap_pkg::DIV_INV_W: begin
        div_cmd.num = sap_pkg::CUR_W'(1);
        div_cmd.den = geom.placed ? geom.w : aw;
      end
      default: begin
        div_cmd.num = sap_pkg::CUR_W'(1);
        div_cmd.den = geom.placed ? geom.h : ah;
      end
    endcase
  end

  sap_div u_div (
    .clk  (clk),
    .rst  (rst),
    .cmd  (div_cmd),
    .stat (div_stat)
  );

  always_comb begin
    result_next.placed = geom.placed;
    result_next.inv_w  = quot[sap_pkg::DIV_INV_W];
    result_next.inv_h  = quot[sap_pkg::DIV_INV_H];
    if (geom.placed) begin
      result_next.pos_x  = geom.cx[sap_pkg::DIM_W-1:0];
      result_next.pos_y  = geom.cy[sap_pkg::DIM_W-1:0];
      result_next.size_w = geom.w;
      result_next.size_h = geom.h;
      result_next.uv_u   = quot[sap_pkg::DIV_UV_U];
      result_next.uv_v   = quot[sap_pkg::DIV_UV_V];
      result_next.uv_w   = quot[sap_pkg::DIV_UV_W];
      result_next.uv_h   = quot[sap_pkg::DIV_UV_H];
    end else begin
      // rejected: full-atlas uv
      result_next.pos_x  = '0;
      result_next.pos_y  = '0;
      result_next.size_w = sap_pkg::DIM_W'(1);
      result_next.size_h = sap_pkg::DIM_W'(1);
      result_next.uv_u   = '0;
      result_next.uv_v   = '0;
      result_next.uv_w   = sap_pkg::Q16_ONE;
      result_next.uv_h   = sap_pkg::Q16_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
      k            <= '0;
      issue        <= 1'b0;
    end else begin
      if (state == ST_DONE && out_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE:  if (accept) state <= ST_CLAMP;
        ST_CLAMP: state <= ST_FIT;
        ST_FIT:   state <= ST_ROW;
        ST_ROW:   state <= ST_CHECK;
        ST_CHECK: begin
          state <= ST_DIV;
          k     <= '0;
          issue <= 1'b1;
        end
        ST_DIV: begin
          issue <= 1'b0;
          if (div_stat.done) begin
            quot[k] <= div_stat.quot;
            if (k == sap_pkg::DIV_INV_H) state <= ST_DONE;
            else k <= k + 1'b1;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            result <= result_next;
            state  <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `SAP_ASSERT_NEXT(a_accept_busy, accept, item_stall)
  `SAP_ASSERT_IMPL(a_div_in_seq, div_stat.done, state == ST_DIV)
  `SAP_ASSERT_IMPL(a_reject_pos, result_valid && !result.placed, result.pos_x == '0)
  `SAP_ASSERT_IMPL(a_reject_uv, result_valid && !result.placed, result.uv_w == sap_pkg::Q16_ONE)
  `SAP_ASSERT_NEXT(a_result_load, state == ST_DONE && out_free, result_valid && state == ST_IDLE)

endmodule
